// ===== rtl/core/tspc_pkg.sv =====
// ----------------------------------------------------------------------------
// tspc_pkg - shared types and constants of the PID packet counter table
// Beat types of the packet and result channels, the controller state type,
// the flags carried along the cell chain and the PID framing constants.
// ----------------------------------------------------------------------------
package tspc_pkg;

	// PID framing: high bits from header byte 1, low byte from header byte 2
	localparam int          PID_BITS       = 13;
	localparam logic [7:0]  PID_HIGH_MASK  = 8'h1f;
	localparam int          PID_HIGH_SCALE = 256;
	localparam int          PID_LOW_BITS   = $clog2(PID_HIGH_SCALE);
	localparam int          PID_HIGH_BITS  = PID_BITS - PID_LOW_BITS;

	// one transport packet header beat
	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] header_byte1;
		logic [7:0] header_byte2;
	} pkt_beat_t;

	// one result beat
	typedef struct packed {
		logic [12:0] packet_pid;
		logic [5:0]  slot;
		logic [31:0] packet_count;
		logic        was_new;
		logic        table_full;
		logic [6:0]  entries_used;
	} res_beat_t;

	// control flags travelling down the cell chain with a lookup
	typedef struct packed {
		logic valid;
		logic done;
		logic is_new;
	} probe_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HOLD
	} state_t;

endpackage

// ===== rtl/core/tspc_cell.sv =====
// ----------------------------------------------------------------------------
// tspc_cell - one table slot of the PID counter chain
// Holds the PID and packet count of its slot for every channel. A lookup
// probe passes through, registered on to the next cell; the cell claims it on a
// PID match (saturating increment) or when it is the first free slot (append).
// ----------------------------------------------------------------------------
module tspc_cell #(
	parameter  int TABLE_ENTRIES = 64,
	parameter  int CHANNELS      = 4,
	parameter  int COUNT_BITS    = 32,
	parameter  int INDEX         = 0,
	localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CH_W-1:0]        ch_idx,
	input  logic [12:0]            pid,
	input  logic [FILL_W-1:0]      used,
	input  tspc_pkg::probe_flags_t flags_in,
	input  logic [SLOT_W-1:0]      slot_in,
	input  logic [COUNT_BITS-1:0]  count_in,
	output tspc_pkg::probe_flags_t flags_out,
	output logic [SLOT_W-1:0]      slot_out,
	output logic [COUNT_BITS-1:0]  count_out
);
	import tspc_pkg::*;

	localparam logic [FILL_W-1:0] IDX_FILL = FILL_W'(INDEX);
	localparam logic [SLOT_W-1:0] IDX_SLOT = SLOT_W'(INDEX);

	logic [12:0]           pid_q [CHANNELS];
	logic [COUNT_BITS-1:0] cnt_q [CHANNELS];

	probe_flags_t          flags_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [12:0]           cur_pid;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [COUNT_BITS-1:0] sat_cnt;
	logic                  open;
	logic                  hit;
	logic                  append;

	// decide whether this slot claims the passing probe
	always_comb begin
		cur_pid = pid_q[ch_idx];
		cur_cnt = cnt_q[ch_idx];
		sat_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
		open    = flags_in.valid && !flags_in.done;
		hit     = open && (IDX_FILL < used) && (cur_pid == pid);
		append  = open && (IDX_FILL == used);
	end

	// update the slot contents of the addressed channel
	always_ff @(posedge clk) begin
		if (hit) begin
			cnt_q[ch_idx] <= sat_cnt;
		end else if (append) begin
			pid_q[ch_idx] <= pid;
			cnt_q[ch_idx] <= COUNT_BITS'(1);
		end
	end

	// advance the probe flags to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.valid  <= flags_in.valid;
			flags_q.done   <= flags_in.done | hit | append;
			flags_q.is_new <= flags_in.is_new | append;
		end
	end

	// advance slot and count, replaced when this cell claims the probe
	always_ff @(posedge clk) begin
		if (hit || append) begin
			slot_q <= IDX_SLOT;
		end else begin
			slot_q <= slot_in;
		end
		if (hit) begin
			count_q <= sat_cnt;
		end else if (append) begin
			count_q <= COUNT_BITS'(1);
		end else begin
			count_q <= count_in;
		end
	end

	assign flags_out = flags_q;
	assign slot_out  = slot_q;
	assign count_out = count_q;

endmodule

// ===== rtl/core/ts_pid_packet_counter_table_unit.sv =====
// ----------------------------------------------------------------------------
// ts_pid_packet_counter_table_unit - per-channel PID packet counter
// Extracts the PID of each transport packet header, finds or appends it in
// the channel's table and reports slot, count and fill level.
// ----------------------------------------------------------------------------
// A packet header beat is accepted only while the unit is idle, so no new
// beat is taken until the previous result has reached the output register.
// For a valid channel the lookup probe walks the chain of table cells one
// slot per clock, then the result is registered and handed to the output
// register. A beat for a channel at or above CHANNELS touches no table; its
// result is formed at acceptance. A new header is accepted while the
// previous result still waits on the result channel; a finished lookup
// then holds until that result is taken. Tables are empty after reset,
// with no clearing pass.
// ----------------------------------------------------------------------------
module ts_pid_packet_counter_table_unit #(
	parameter int TABLE_ENTRIES = 64,
	parameter int CHANNELS      = 4,
	parameter int COUNT_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pkt_valid,
	output logic                pkt_ready,
	input  tspc_pkg::pkt_beat_t pkt,
	output logic                res_valid,
	input  logic                res_ready,
	output tspc_pkg::res_beat_t res
);
	import tspc_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam int RES_REST_W = $bits(res_beat_t) - PID_BITS;
	localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(TABLE_ENTRIES);

	state_t                state_q;
	state_t                state_d;

	logic [FILL_W-1:0]     fill_q [CHANNELS];
	logic [CH_W-1:0]       req_ch_q;
	logic [12:0]           req_pid_q;
	logic [FILL_W-1:0]     req_used_q;
	logic                  start_q;
	res_beat_t             pend_q;
	res_beat_t             res_q;
	logic                  res_valid_q;

	logic [12:0]           pid_w;
	logic [CH_W-1:0]       ch_w;
	logic                  ch_ok;
	logic                  pkt_take;
	logic                  tail_end;
	logic                  pend_move;

	probe_flags_t          flags_c [TABLE_ENTRIES+1];
	logic [SLOT_W-1:0]     slot_c  [TABLE_ENTRIES+1];
	logic [COUNT_BITS-1:0] count_c [TABLE_ENTRIES+1];

	// form the PID and check the channel number
	always_comb begin
		pid_w = {PID_HIGH_BITS'(pkt.header_byte1 & PID_HIGH_MASK), pkt.header_byte2};
		ch_w  = CH_W'(pkt.channel);
		ch_ok = (32'(pkt.channel) < CHANNELS);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pkt_valid) begin
					state_d = ch_ok ? ST_SEARCH : ST_HOLD;
				end
			end
			ST_SEARCH: begin
				if (flags_c[TABLE_ENTRIES].valid) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!res_valid_q || res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		pkt_ready = 1'b0;
		tail_end  = 1'b0;
		pend_move = 1'b0;
		case (state_q)
			ST_IDLE:   pkt_ready = 1'b1;
			ST_SEARCH: tail_end  = flags_c[TABLE_ENTRIES].valid;
			ST_HOLD:   pend_move = !res_valid_q || res_ready;
			default: begin
				pkt_ready = 1'b0;
			end
		endcase
		pkt_take = pkt_valid && pkt_ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			res_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				fill_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			start_q <= pkt_take && ch_ok;
			if (pend_move) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (tail_end && flags_c[TABLE_ENTRIES].is_new) begin
				fill_q[req_ch_q] <= req_used_q + 1'b1;
			end
		end
	end

	// hold the request, build the pending result, load the output beat
	always_ff @(posedge clk) begin
		if (pkt_take) begin
			req_ch_q   <= ch_w;
			req_pid_q  <= pid_w;
			req_used_q <= fill_q[ch_w];
			if (!ch_ok) begin
				pend_q <= {pid_w, {RES_REST_W{1'b0}}};
			end
		end
		if (tail_end) begin
			pend_q.packet_pid   <= req_pid_q;
			pend_q.slot         <= 6'(slot_c[TABLE_ENTRIES]);
			pend_q.packet_count <= 32'(count_c[TABLE_ENTRIES]);
			pend_q.was_new      <= flags_c[TABLE_ENTRIES].is_new;
			pend_q.table_full   <= !flags_c[TABLE_ENTRIES].done;
			pend_q.entries_used <= 7'(req_used_q + FILL_W'(flags_c[TABLE_ENTRIES].is_new));
		end
		if (pend_move) begin
			res_q <= pend_q;
		end
	end

	// feed the head of the chain
	always_comb begin
		flags_c[0]        = '0;
		flags_c[0].valid  = start_q;
		slot_c[0]         = '0;
		count_c[0]        = '0;
	end

	// chain of table cells, one per slot
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		tspc_cell #(
			.TABLE_ENTRIES (TABLE_ENTRIES),
			.CHANNELS      (CHANNELS),
			.COUNT_BITS    (COUNT_BITS),
			.INDEX         (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ch_idx    (req_ch_q),
			.pid       (req_pid_q),
			.used      (req_used_q),
			.flags_in  (flags_c[i]),
			.slot_in   (slot_c[i]),
			.count_in  (count_c[i]),
			.flags_out (flags_c[i+1]),
			.slot_out  (slot_c[i+1]),
			.count_out (count_c[i+1])
		);
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a probe only leaves the chain while a search is running
	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		flags_c[TABLE_ENTRIES].valid |-> state_q == ST_SEARCH)
		else $error("probe left the chain outside a search");

	// an unclaimed probe means the table was full
	a_miss_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(flags_c[TABLE_ENTRIES].valid && !flags_c[TABLE_ENTRIES].done)
		|-> req_used_q == FULL_LEVEL)
		else $error("lookup missed on a table with free slots");

	// an append lands exactly at the fill level
	a_append_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(flags_c[TABLE_ENTRIES].valid && flags_c[TABLE_ENTRIES].is_new)
		|-> FILL_W'(slot_c[TABLE_ENTRIES]) == req_used_q)
		else $error("new entry appended away from the fill level");

	// the fill level of a search never exceeds the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> req_used_q <= FULL_LEVEL)
		else $error("fill level beyond table size");

endmodule

// ===== bench/ts_pid_packet_counter_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ts_pid_packet_counter_table_unit_tb - self-checking bench of the PID counter
// Drives transport packet header beats with random gaps and back-pressure,
// predicts every result beat from a behavioural copy of the per-channel PID
// tables, and compares each result beat field by field in arrival order.
// A flood phase fills one channel's table to exercise the full-table drop.
// ----------------------------------------------------------------------------
module ts_pid_packet_counter_table_unit_tb;
	import tspc_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int CHANNELS      = 4;
	localparam int COUNT_BITS    = 32;
	localparam int MIX_BEATS     = 370;
	localparam int MAX_REPORTS   = 10;
	localparam int SETTLE_CYCLES = 100;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      pkt_valid = 1'b0;
	logic      pkt_ready;
	pkt_beat_t pkt       = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_beat_t res;
	bit        steady    = 1'b0;

	// Behavioural PID tables and the queue of result beats still owed
	class pid_tally_board;
		logic [PID_BITS-1:0]   pid_tab [CHANNELS*TABLE_ENTRIES];
		logic [COUNT_BITS-1:0] cnt_tab [CHANNELS*TABLE_ENTRIES];
		int                    fill [CHANNELS];
		res_beat_t             owed_q [$];
		int                    fail_count;

		function new();
			foreach (cnt_tab[i]) cnt_tab[i] = '0;
			foreach (fill[i]) fill[i] = 0;
			fail_count = 0;
		endfunction

		function void flag(string msg);
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("MISMATCH at %0t: %s", $time, msg);
		endfunction

		function int used(int ch);
			return fill[ch];
		endfunction

		function logic [PID_BITS-1:0] stored_pid(int ch, int idx);
			return pid_tab[ch*TABLE_ENTRIES + idx];
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

		// Look the PID up, update the table and work out the result beat
		function res_beat_t tally(pkt_beat_t b);
			res_beat_t           r;
			logic [PID_BITS-1:0] pid;
			int                  ch, base, level, idx;
			bit                  hit;
			pid = PID_BITS'((b.header_byte1 & PID_HIGH_MASK) * PID_HIGH_SCALE
				+ b.header_byte2);
			r = '0;
			r.packet_pid = pid;
			ch = int'(b.channel);
			// channels beyond the table set report the PID and nothing else
			if (ch >= CHANNELS)
				return r;
			base  = ch * TABLE_ENTRIES;
			level = fill[ch];
			hit   = 1'b0;
			idx   = 0;
			for (int i = 0; i < level; i++) begin
				if (!hit && pid_tab[base+i] == pid) begin
					hit = 1'b1;
					idx = i;
				end
			end
			if (hit) begin
				// saturate at the counter maximum
				if (cnt_tab[base+idx] != '1)
					cnt_tab[base+idx] = cnt_tab[base+idx] + 1'b1;
				r.slot         = 6'(idx);
				r.packet_count = 32'(cnt_tab[base+idx]);
			end else if (level < TABLE_ENTRIES) begin
				pid_tab[base+level] = pid;
				cnt_tab[base+level] = 1;
				r.slot         = 6'(level);
				r.packet_count = 32'd1;
				r.was_new      = 1'b1;
				level++;
				fill[ch] = level;
			end else begin
				// unseen PID and no free slot: drop
				r.table_full = 1'b1;
			end
			r.entries_used = 7'(level);
			return r;
		endfunction

		function void note_packet(pkt_beat_t b);
			owed_q.push_back(tally(b));
		endfunction

		function void check_result(res_beat_t got);
			res_beat_t want;
			if (owed_q.size() == 0) begin
				flag($sformatf("result beat with none owed, pid %h slot %0d count %0d",
					got.packet_pid, got.slot, got.packet_count));
				return;
			end
			want = owed_q.pop_front();
			if (got.packet_pid !== want.packet_pid || got.slot !== want.slot ||
					got.packet_count !== want.packet_count ||
					got.was_new !== want.was_new || got.table_full !== want.table_full ||
					got.entries_used !== want.entries_used)
				flag($sformatf({"exp/act pid %h/%h slot %0d/%0d count %0d/%0d ",
					"new %b/%b full %b/%b used %0d/%0d"},
					want.packet_pid, got.packet_pid, want.slot, got.slot,
					want.packet_count, got.packet_count, want.was_new, got.was_new,
					want.table_full, got.table_full, want.entries_used, got.entries_used));
		endfunction

		function void close_out();
			if (owed_q.size() != 0)
				flag($sformatf("%0d result beats never arrived", owed_q.size()));
		endfunction
	endclass

	pid_tally_board board = new();

	ts_pid_packet_counter_table_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.CHANNELS     (CHANNELS),
		.COUNT_BITS   (COUNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.pkt      (pkt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(12, 60);
	endfunction

	// Offer one header beat and hold it until accepted
	task automatic send_hdr(input logic [1:0] ch, input logic [7:0] b1, input logic [7:0] b2);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pkt       <= '{channel: ch, header_byte1: b1, header_byte2: b2};
		pkt_valid <= 1'b1;
		do @(posedge clk); while (!pkt_ready);
		board.note_packet(pkt);
	endtask

	// Random PID, random junk in the top three bits of header byte 1
	task automatic send_fresh(input logic [1:0] ch);
		logic [2:0]  top;
		logic [12:0] pid;
		top = 3'($urandom);
		pid = 13'($urandom);
		send_hdr(ch, {top, pid[12:8]}, pid[7:0]);
	endtask

	// PID already stored for the channel, so the lookup hits
	task automatic send_known(input logic [1:0] ch);
		logic [2:0]  top;
		logic [12:0] pid;
		top = 3'($urandom);
		pid = board.stored_pid(ch, $urandom_range(0, board.used(ch) - 1));
		send_hdr(ch, {top, pid[12:8]}, pid[7:0]);
	endtask

	// Hold off the sender until every owed result beat has come back
	task automatic drain_results();
		@(negedge clk);
		pkt_valid <= 1'b0;
		while (board.outstanding() != 0) @(negedge clk);
	endtask

	// Result side back-pressure
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = idle_len();
			@(negedge clk);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// Check every result beat taken
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_result(res);
	end

	initial begin : stimulus
		logic [1:0] ch;
		logic [1:0] fc;
		int         sel;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: PID extremes, hits, masked high bits, channel independence
		send_hdr(2'd0, 8'h00, 8'h00);
		send_hdr(2'd0, 8'h00, 8'h00);
		send_hdr(2'd0, 8'he0, 8'h00);
		send_hdr(2'd0, 8'hff, 8'hff);
		send_hdr(2'd0, 8'h1f, 8'hff);
		send_hdr(2'd1, 8'h00, 8'h00);
		send_hdr(2'd1, 8'h1f, 8'h00);
		send_hdr(2'd1, 8'h00, 8'hff);
		send_hdr(2'd2, 8'haa, 8'h55);
		send_hdr(2'd3, 8'h55, 8'haa);
		send_hdr(2'd2, 8'h0a, 8'h55);
		send_hdr(2'd3, 8'hf5, 8'haa);
		send_hdr(2'd3, 8'hff, 8'hff);
		send_hdr(2'd2, 8'h10, 8'h00);
		send_hdr(2'd1, 8'h80, 8'h00);
		send_hdr(2'd0, 8'h01, 8'h00);
		send_hdr(2'd0, 8'h00, 8'h01);

		// Flood one channel to full, then miss and hit on the full table
		fc = 2'($urandom);
		while (board.used(fc) < TABLE_ENTRIES)
			send_fresh(fc);
		repeat (8) send_fresh(fc);
		repeat (8) send_known(fc);

		// Mixed traffic, mostly hits on stored PIDs
		for (int n = 0; n < MIX_BEATS; n++) begin
			steady = (n >= 120 && n < 170);
			if (n == 250)
				drain_results();
			ch  = 2'($urandom);
			sel = $urandom_range(0, 99);
			if (sel < 65 && board.used(ch) > 0)
				send_known(ch);
			else if (sel < 85)
				send_fresh(ch);
			else
				send_hdr(2'($urandom), 8'($urandom), 8'($urandom));
		end
		steady = 1'b0;

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		board.close_out();
		if (board.fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tspc_pkg.sv
rtl/core/tspc_cell.sv
rtl/core/ts_pid_packet_counter_table_unit.sv
bench/ts_pid_packet_counter_table_unit_tb.sv
